@@ rtl/mcas_pkg.sv @@
// Shared types, constants and sequencer states of the assignment solver.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package mcas_pkg;

    localparam int COST_W = 32;
    localparam int POT_W  = 40;
    localparam int SUM_W  = 42;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 4;

    typedef logic signed [COST_W-1:0] t_cost;
    typedef logic signed [POT_W-1:0]  t_pot;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [IDX_W-1:0]         t_idx;

    localparam t_pot POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
    localparam t_pot POT_MIN = {1'b1, {(POT_W-1){1'b0}}};

    // at most this many results per run
    localparam t_cnt RES_LIMIT = 5'd16;

    // result status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_SHORT = 1'b1;

    // configuration register indexes
    localparam logic REG_DRONES  = 1'b0;
    localparam logic REG_TARGETS = 1'b1;

    typedef struct packed {
        t_sum a;
        t_sum b;
        logic sub;
    } t_alu_req;

    typedef struct packed {
        t_sum sum;
        t_pot sat;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR,
        S_CLR,
        S_RINIT,
        S_ITER_A,
        S_ITER_B,
        S_ITER_C,
        S_SCAN_A,
        S_SCAN_B,
        S_SCAN_C,
        S_SCAN_D,
        S_UPD_A,
        S_UPD_B,
        S_UPD_C,
        S_CHK_A,
        S_CHK_B,
        S_AUG_A,
        S_AUG_B,
        S_AUG_C,
        S_OUT_A,
        S_OUT_B,
        S_OUT_C,
        S_OUT_END
    } t_state;

endpackage

`default_nettype wire

@@ rtl/mcas_in_if.sv @@
// Input channel of the solver: one cost entry per item.
// Depends on mcas_pkg for field types.
`default_nettype none

interface mcas_in_if;
    logic             valid;
    logic             ready;
    mcas_pkg::t_idx   drone_index;
    mcas_pkg::t_idx   target_index;
    mcas_pkg::t_cost  cost_value;
    logic             load_done;

    modport source (output valid, drone_index, target_index, cost_value, load_done,
                    input ready);
    modport sink   (input valid, drone_index, target_index, cost_value, load_done,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/mcas_out_if.sv @@
// Result channel of the solver: one drone/target pair per item.
// Depends on mcas_pkg for field types.
`default_nettype none

interface mcas_out_if;
    logic             valid;
    logic             ready;
    mcas_pkg::t_idx   assigned_drone;
    mcas_pkg::t_idx   assigned_target;
    mcas_pkg::t_cost  pair_cost;
    logic             status;
    logic             final_result;

    modport source (output valid, assigned_drone, assigned_target, pair_cost, status,
                    final_result, input ready);
    modport sink   (input valid, assigned_drone, assigned_target, pair_cost, status,
                    final_result, output ready);
endinterface

`default_nettype wire

@@ rtl/mcas_cfg.sv @@
// APB register block holding the drone and target counts.
// Depends on mcas_pkg; counts are saturated to their legal range on write.
`default_nettype none

module mcas_cfg #(
    parameter int MAX_DRONES  = 16,
    parameter int MAX_TARGETS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output mcas_pkg::t_cnt           o_drones,
    output mcas_pkg::t_cnt           o_targets
);

    localparam mcas_pkg::t_cnt DRONES_RST  = 5'((MAX_DRONES  < 16) ? MAX_DRONES  : 16);
    localparam mcas_pkg::t_cnt TARGETS_RST = 5'((MAX_TARGETS < 16) ? MAX_TARGETS : 16);

    mcas_pkg::t_cnt r_drones, r_targets;
    mcas_pkg::t_cnt n_drones, n_targets;
    mcas_pkg::t_cnt raw;
    logic           wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign raw    = pwdata[mcas_pkg::CNT_W-1:0];

    always_comb begin
        n_drones  = r_drones;
        n_targets = r_targets;
        if (wr && paddr[2] == mcas_pkg::REG_DRONES) begin
            if (raw == '0) begin
                n_drones = 5'd1;
            end else if (32'(raw) > MAX_DRONES) begin
                n_drones = 5'(MAX_DRONES);
            end else begin
                n_drones = raw;
            end
        end
        if (wr && paddr[2] == mcas_pkg::REG_TARGETS) begin
            if (raw == '0) begin
                n_targets = 5'd1;
            end else if (32'(raw) > MAX_TARGETS) begin
                n_targets = 5'(MAX_TARGETS);
            end else begin
                n_targets = raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drones  <= DRONES_RST;
            r_targets <= TARGETS_RST;
        end else begin
            r_drones  <= n_drones;
            r_targets <= n_targets;
        end
    end

    assign prdata = (paddr[2] == mcas_pkg::REG_TARGETS) ? {27'd0, r_targets}
                                                         : {27'd0, r_drones};
    assign o_drones  = r_drones;
    assign o_targets = r_targets;

endmodule

`default_nettype wire

@@ rtl/mcas_cost_mem.sv @@
// Cost matrix store: one write port for loading, one registered read port.
// Depends on mcas_pkg for the entry type.
`default_nettype none

module mcas_cost_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire mcas_pkg::t_cost   i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output mcas_pkg::t_cost        o_rdata
);

    mcas_pkg::t_cost r_mem [0:DEPTH-1];
    mcas_pkg::t_cost r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

@@ rtl/mcas_alu.sv @@
// Shared add/subtract unit with saturation to the 40-bit potential range.
// Depends on mcas_pkg for request and response types.
`default_nettype none

module mcas_alu (
    input  wire mcas_pkg::t_alu_req i_req,
    output mcas_pkg::t_alu_rsp      o_rsp
);

    mcas_pkg::t_sum sum;

    assign sum = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);

    always_comb begin
        o_rsp.sum = sum;
        if (sum > mcas_pkg::t_sum'(mcas_pkg::POT_MAX)) begin
            o_rsp.sat = mcas_pkg::POT_MAX;
        end else if (sum < mcas_pkg::t_sum'(mcas_pkg::POT_MIN)) begin
            o_rsp.sat = mcas_pkg::POT_MIN;
        end else begin
            o_rsp.sat = sum[mcas_pkg::POT_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/mcas_solver.sv @@
// Sequencer of the Hungarian solve: potentials, slacks and matching in small
// memories, one column at a time through the shared mcas_alu.
// Depends on mcas_pkg, mcas_alu and mcas_out_if.
`default_nettype none

module mcas_solver #(
    parameter int MAX_DRONES  = 16,
    parameter int MAX_TARGETS = 16,
    parameter int DW          = 5,
    parameter int TW          = 5,
    parameter int AW          = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_short,
    input  wire logic [DW-1:0]   i_nd,
    input  wire logic [TW-1:0]   i_nt,
    output logic                 o_idle,
    output logic [AW-1:0]        o_caddr,
    input  wire mcas_pkg::t_cost i_cdata,
    mcas_out_if.source           o_out
);

    localparam int SW = DW + 1;

    mcas_pkg::t_state r_state, n_state;

    logic [DW-1:0]   r_d, n_d, r_cur, n_cur, r_next, n_next, r_p, n_p;
    logic [SW-1:0]   r_step, n_step;
    logic [TW-1:0]   r_t, n_t, r_row, n_row, r_m, n_m;
    mcas_pkg::t_pot  r_urow, n_urow, r_delta, n_delta, r_meff, n_meff;
    mcas_pkg::t_sum  r_tmp, n_tmp;
    mcas_pkg::t_cnt  r_n, n_n;
    logic            r_pend, n_pend;
    mcas_pkg::t_idx  r_pend_d, n_pend_d, r_pend_t, n_pend_t;
    mcas_pkg::t_cost r_pend_c, n_pend_c;
    logic            r_ov, n_ov, r_os, n_os, r_of, n_of;
    mcas_pkg::t_idx  r_od, n_od, r_ot, n_ot;
    mcas_pkg::t_cost r_oc, n_oc;

    // solver memories, registered read
    mcas_pkg::t_pot r_u     [0:MAX_TARGETS];
    mcas_pkg::t_pot r_v     [0:MAX_DRONES];
    mcas_pkg::t_pot r_minv  [0:MAX_DRONES];
    logic [TW-1:0]  r_match [0:MAX_DRONES];
    logic [DW-1:0]  r_prev  [0:MAX_DRONES];
    logic           r_vis   [0:MAX_DRONES];

    mcas_pkg::t_pot u_q, v_q, minv_q;
    logic [TW-1:0]  match_q;
    logic [DW-1:0]  prev_q;
    logic           vis_q;

    logic           u_we, v_we, minv_we, match_we, prev_we, vis_we;
    logic [TW-1:0]  u_wa, u_ra;
    logic [DW-1:0]  v_wa, minv_wa, match_wa, prev_wa, vis_wa, match_ra, prev_ra;
    mcas_pkg::t_pot u_wd, v_wd, minv_wd;
    logic [TW-1:0]  match_wd;
    logic [DW-1:0]  prev_wd;
    logic           vis_wd;

    mcas_pkg::t_alu_req alu_req;
    mcas_pkg::t_alu_rsp alu_rsp;

    logic           out_free, row_ok, upd_last;
    logic [TW-1:0]  caddr_row;
    logic [DW-1:0]  clamp_p;

    mcas_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (u_we) r_u[u_wa] <= u_wd;
        if (v_we) r_v[v_wa] <= v_wd;
        if (minv_we) r_minv[minv_wa] <= minv_wd;
        if (match_we) r_match[match_wa] <= match_wd;
        if (prev_we) r_prev[prev_wa] <= prev_wd;
        if (vis_we) r_vis[vis_wa] <= vis_wd;
        u_q     <= r_u[u_ra];
        v_q     <= r_v[r_d];
        minv_q  <= r_minv[r_d];
        vis_q   <= r_vis[r_d];
        match_q <= r_match[match_ra];
        prev_q  <= r_prev[prev_ra];
    end

    assign out_free = !r_ov || o_out.ready;
    assign row_ok   = (r_row != '0) && (r_row <= i_nt);
    assign upd_last = (r_d == i_nd);
    assign clamp_p  = (prev_q > i_nd) ? '0 : prev_q;

    // cost entry of column r_d, row caddr_row
    always_comb begin
        case (r_state)
            mcas_pkg::S_OUT_B: caddr_row = match_q;
            mcas_pkg::S_OUT_C: caddr_row = r_m;
            default: caddr_row = r_row;
        endcase
    end
    assign o_caddr = AW'((32'(r_d) - 32'd1) * MAX_TARGETS + 32'(caddr_row) - 32'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcas_pkg::S_IDLE;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d      <= n_d;
        r_cur    <= n_cur;
        r_next   <= n_next;
        r_p      <= n_p;
        r_step   <= n_step;
        r_t      <= n_t;
        r_row    <= n_row;
        r_m      <= n_m;
        r_urow   <= n_urow;
        r_delta  <= n_delta;
        r_meff   <= n_meff;
        r_tmp    <= n_tmp;
        r_n      <= n_n;
        r_pend_d <= n_pend_d;
        r_pend_t <= n_pend_t;
        r_pend_c <= n_pend_c;
        r_od     <= n_od;
        r_ot     <= n_ot;
        r_oc     <= n_oc;
        r_os     <= n_os;
        r_of     <= n_of;
    end

    always_comb begin
        n_state  = r_state;
        n_d      = r_d;
        n_cur    = r_cur;
        n_next   = r_next;
        n_p      = r_p;
        n_step   = r_step;
        n_t      = r_t;
        n_row    = r_row;
        n_m      = r_m;
        n_urow   = r_urow;
        n_delta  = r_delta;
        n_meff   = r_meff;
        n_tmp    = r_tmp;
        n_n      = r_n;
        n_pend   = r_pend;
        n_pend_d = r_pend_d;
        n_pend_t = r_pend_t;
        n_pend_c = r_pend_c;
        n_ov     = r_ov && !o_out.ready;
        n_od     = r_od;
        n_ot     = r_ot;
        n_oc     = r_oc;
        n_os     = r_os;
        n_of     = r_of;

        u_we = 1'b0;     u_wa = TW'(r_d);   u_wd = '0;       u_ra = r_row;
        v_we = 1'b0;     v_wa = r_d;        v_wd = '0;
        minv_we = 1'b0;  minv_wa = r_d;     minv_wd = mcas_pkg::POT_MAX;
        match_we = 1'b0; match_wa = r_d;    match_wd = '0;   match_ra = r_d;
        prev_we = 1'b0;  prev_wa = r_d;     prev_wd = '0;    prev_ra = r_cur;
        vis_we = 1'b0;   vis_wa = r_d;      vis_wd = 1'b0;

        alu_req = '0;

        case (r_state)
            mcas_pkg::S_IDLE: begin
                if (i_start) begin
                    n_d     = '0;
                    n_state = i_short ? mcas_pkg::S_ERR : mcas_pkg::S_CLR;
                end
            end

            mcas_pkg::S_ERR: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_od    = '0;
                    n_ot    = '0;
                    n_oc    = '0;
                    n_os    = mcas_pkg::ST_SHORT;
                    n_of    = 1'b1;
                    n_state = mcas_pkg::S_IDLE;
                end
            end

            // zero potentials, matching and back links
            mcas_pkg::S_CLR: begin
                u_we     = (32'(r_d) <= 32'(i_nt));
                v_we     = 1'b1;
                match_we = 1'b1;
                prev_we  = 1'b1;
                if (upd_last) begin
                    n_t     = TW'(1);
                    n_d     = '0;
                    n_state = mcas_pkg::S_RINIT;
                end else begin
                    n_d = r_d + DW'(1);
                end
            end

            // start of a row pass: reset slacks and visited marks, put the row in column 0
            mcas_pkg::S_RINIT: begin
                minv_we = 1'b1;
                vis_we  = 1'b1;
                if (r_d == '0) begin
                    match_we = 1'b1;
                    match_wd = r_t;
                end
                if (upd_last) begin
                    n_cur   = '0;
                    n_step  = '0;
                    n_state = mcas_pkg::S_ITER_A;
                end else begin
                    n_d = r_d + DW'(1);
                end
            end

            mcas_pkg::S_ITER_A: begin
                match_ra = r_cur;
                vis_we   = 1'b1;
                vis_wa   = r_cur;
                vis_wd   = 1'b1;
                n_state  = mcas_pkg::S_ITER_B;
            end

            mcas_pkg::S_ITER_B: begin
                n_row   = match_q;
                u_ra    = match_q;
                n_delta = mcas_pkg::POT_MAX;
                n_next  = '0;
                n_state = mcas_pkg::S_ITER_C;
            end

            mcas_pkg::S_ITER_C: begin
                n_urow  = u_q;
                n_d     = DW'(1);
                n_state = mcas_pkg::S_SCAN_A;
            end

            mcas_pkg::S_SCAN_A: begin
                n_state = mcas_pkg::S_SCAN_B;
            end

            mcas_pkg::S_SCAN_B: begin
                alu_req.a   = mcas_pkg::t_sum'(i_cdata);
                alu_req.b   = mcas_pkg::t_sum'(v_q);
                alu_req.sub = 1'b1;
                n_tmp       = alu_rsp.sum;
                n_meff      = minv_q;
                if (vis_q) begin
                    if (upd_last) begin
                        n_d     = '0;
                        n_state = mcas_pkg::S_UPD_A;
                    end else begin
                        n_d     = r_d + DW'(1);
                        n_state = mcas_pkg::S_SCAN_A;
                    end
                end else if (row_ok) begin
                    n_state = mcas_pkg::S_SCAN_C;
                end else begin
                    n_state = mcas_pkg::S_SCAN_D;
                end
            end

            mcas_pkg::S_SCAN_C: begin
                alu_req.a   = r_tmp;
                alu_req.b   = mcas_pkg::t_sum'(r_urow);
                alu_req.sub = 1'b1;
                if (alu_rsp.sum < mcas_pkg::t_sum'(minv_q)) begin
                    minv_we = 1'b1;
                    minv_wd = alu_rsp.sat;
                    prev_we = 1'b1;
                    prev_wd = r_cur;
                    n_meff  = alu_rsp.sat;
                end
                n_state = mcas_pkg::S_SCAN_D;
            end

            mcas_pkg::S_SCAN_D: begin
                if (r_meff < r_delta) begin
                    n_delta = r_meff;
                    n_next  = r_d;
                end
                if (upd_last) begin
                    n_d     = '0;
                    n_state = mcas_pkg::S_UPD_A;
                end else begin
                    n_d     = r_d + DW'(1);
                    n_state = mcas_pkg::S_SCAN_A;
                end
            end

            mcas_pkg::S_UPD_A: begin
                n_state = mcas_pkg::S_UPD_B;
            end

            mcas_pkg::S_UPD_B: begin
                alu_req.a   = mcas_pkg::t_sum'(vis_q ? v_q : minv_q);
                alu_req.b   = mcas_pkg::t_sum'(r_delta);
                alu_req.sub = 1'b1;
                if (vis_q) begin
                    v_we = 1'b1;
                    v_wd = alu_rsp.sat;
                end else begin
                    minv_we = 1'b1;
                    minv_wd = alu_rsp.sat;
                end
                if (vis_q && match_q <= i_nt) begin
                    u_ra    = match_q;
                    n_m     = match_q;
                    n_state = mcas_pkg::S_UPD_C;
                end else if (upd_last) begin
                    n_cur   = r_next;
                    n_step  = r_step + SW'(1);
                    n_state = mcas_pkg::S_CHK_A;
                end else begin
                    n_d     = r_d + DW'(1);
                    n_state = mcas_pkg::S_UPD_A;
                end
            end

            mcas_pkg::S_UPD_C: begin
                alu_req.a = mcas_pkg::t_sum'(u_q);
                alu_req.b = mcas_pkg::t_sum'(r_delta);
                u_we      = 1'b1;
                u_wa      = r_m;
                u_wd      = alu_rsp.sat;
                if (upd_last) begin
                    n_cur   = r_next;
                    n_step  = r_step + SW'(1);
                    n_state = mcas_pkg::S_CHK_A;
                end else begin
                    n_d     = r_d + DW'(1);
                    n_state = mcas_pkg::S_UPD_A;
                end
            end

            mcas_pkg::S_CHK_A: begin
                match_ra = r_cur;
                n_state  = mcas_pkg::S_CHK_B;
            end

            mcas_pkg::S_CHK_B: begin
                if (match_q != '0 && r_step <= SW'(i_nd)) begin
                    n_state = mcas_pkg::S_ITER_A;
                end else begin
                    n_step  = '0;
                    n_state = mcas_pkg::S_AUG_A;
                end
            end

            // walk the back links and shift the matching along the path
            mcas_pkg::S_AUG_A: begin
                prev_ra = r_cur;
                n_state = mcas_pkg::S_AUG_B;
            end

            mcas_pkg::S_AUG_B: begin
                n_p      = clamp_p;
                match_ra = clamp_p;
                n_state  = mcas_pkg::S_AUG_C;
            end

            mcas_pkg::S_AUG_C: begin
                match_we = 1'b1;
                match_wa = r_cur;
                match_wd = match_q;
                n_cur    = r_p;
                n_step   = r_step + SW'(1);
                if (r_p != '0 && (r_step + SW'(1)) <= SW'(i_nd)) begin
                    n_state = mcas_pkg::S_AUG_A;
                end else if (r_t == i_nt) begin
                    n_d     = DW'(1);
                    n_n     = '0;
                    n_pend  = 1'b0;
                    n_state = mcas_pkg::S_OUT_A;
                end else begin
                    n_t     = r_t + TW'(1);
                    n_d     = '0;
                    n_state = mcas_pkg::S_RINIT;
                end
            end

            mcas_pkg::S_OUT_A: begin
                match_ra = r_d;
                n_state  = mcas_pkg::S_OUT_B;
            end

            mcas_pkg::S_OUT_B: begin
                n_m = match_q;
                if (match_q != '0 && match_q <= i_nt) begin
                    n_state = mcas_pkg::S_OUT_C;
                end else if (upd_last) begin
                    n_state = mcas_pkg::S_OUT_END;
                end else begin
                    n_d     = r_d + DW'(1);
                    n_state = mcas_pkg::S_OUT_A;
                end
            end

            // hold one result back so the last one can carry the final flag
            mcas_pkg::S_OUT_C: begin
                if (!r_pend || out_free) begin
                    if (r_pend) begin
                        n_ov = 1'b1;
                        n_od = r_pend_d;
                        n_ot = r_pend_t;
                        n_oc = r_pend_c;
                        n_os = mcas_pkg::ST_OK;
                        n_of = 1'b0;
                    end
                    n_pend   = 1'b1;
                    n_pend_d = mcas_pkg::IDX_W'(r_d - DW'(1));
                    n_pend_t = mcas_pkg::IDX_W'(r_m - TW'(1));
                    n_pend_c = i_cdata;
                    n_n      = r_n + 5'd1;
                    if ((r_n + 5'd1) == mcas_pkg::RES_LIMIT || upd_last) begin
                        n_state = mcas_pkg::S_OUT_END;
                    end else begin
                        n_d     = r_d + DW'(1);
                        n_state = mcas_pkg::S_OUT_A;
                    end
                end
            end

            mcas_pkg::S_OUT_END: begin
                if (!r_pend) begin
                    n_state = mcas_pkg::S_IDLE;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_od    = r_pend_d;
                    n_ot    = r_pend_t;
                    n_oc    = r_pend_c;
                    n_os    = mcas_pkg::ST_OK;
                    n_of    = 1'b1;
                    n_pend  = 1'b0;
                    n_state = mcas_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = mcas_pkg::S_IDLE;
            end
        endcase
    end

    assign o_idle                = (r_state == mcas_pkg::S_IDLE);
    assign o_out.valid           = r_ov;
    assign o_out.assigned_drone  = r_od;
    assign o_out.assigned_target = r_ot;
    assign o_out.pair_cost       = r_oc;
    assign o_out.status          = r_os;
    assign o_out.final_result    = r_of;

endmodule

`default_nettype wire

@@ rtl/min_cost_assignment_solver.sv @@
// Minimum-cost assignment solver (Hungarian method). Load cost entries one
// item per cycle into the cost store; each item writes entry (drone, target).
// The item with load_done set also starts a solve over the configured numbers
// of drones (columns) and targets (rows). The block then emits one item per
// matched drone, in drone order, with final_result set on the last one, or a
// single status=1 item when fewer drones than targets are configured.
// Costs are signed Q16.16; potentials and slacks are 40-bit and saturate.
// A solve runs on one shared adder under a sequencer, one column step at a
// time: it clears the memories, then per target row does a setup pass and,
// for each Dijkstra step, a slack scan, a potential update and a test of the
// reached column, then walks the augmenting path; results are then read out
// drone by drone. The input is not ready while a solve or its results are in
// flight; the last result may still wait in the output register while the
// next item is taken. Counts are written through APB at 0x0 (drones) and
// 0x4 (targets), saturated to 1..MAX.
// Depends on mcas_pkg, mcas_in_if, mcas_out_if, mcas_cfg, mcas_cost_mem, mcas_solver.
`default_nettype none

module min_cost_assignment_solver #(
    parameter int MAX_DRONES  = 16,
    parameter int MAX_TARGETS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    mcas_in_if.sink           i_in,
    mcas_out_if.source        o_out,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int DEPTH = MAX_DRONES * MAX_TARGETS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(MAX_DRONES + 1);
    localparam int TW    = $clog2(MAX_TARGETS + 1);

    mcas_pkg::t_cnt cfg_drones, cfg_targets;
    logic           idle, accept, in_range;
    logic [AW-1:0]  waddr, raddr;
    mcas_pkg::t_cost rdata;

    mcas_cfg #(
        .MAX_DRONES  (MAX_DRONES),
        .MAX_TARGETS (MAX_TARGETS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_drones  (cfg_drones),
        .o_targets (cfg_targets)
    );

    // take a new entry only while the sequencer rests
    assign i_in.ready = idle;
    assign accept     = i_in.valid & idle;
    // drop entries outside the configured store
    assign in_range   = (32'(i_in.drone_index) < MAX_DRONES) &&
                        (32'(i_in.target_index) < MAX_TARGETS);
    assign waddr      = AW'(32'(i_in.drone_index) * MAX_TARGETS + 32'(i_in.target_index));

    mcas_cost_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cost_mem (
        .i_clk   (i_clk),
        .i_we    (accept & in_range),
        .i_waddr (waddr),
        .i_wdata (i_in.cost_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mcas_solver #(
        .MAX_DRONES  (MAX_DRONES),
        .MAX_TARGETS (MAX_TARGETS),
        .DW          (DW),
        .TW          (TW),
        .AW          (AW)
    ) u_solver (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept & i_in.load_done),
        .i_short (cfg_drones < cfg_targets),
        .i_nd    (DW'(cfg_drones)),
        .i_nt    (TW'(cfg_targets)),
        .o_idle  (idle),
        .o_caddr (raddr),
        .i_cdata (rdata),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
